// ----- design/spom_pkg.sv -----
// ----------------------------------------------------------------------------
// spom_pkg
// Shared types, codes and constants of the scan point occupancy merge.
// ----------------------------------------------------------------------------
package spom_pkg;

	localparam int FRAME_CELLS_DEF  = 1024;
	localparam int HEIGHT_CELLS_DEF = 1024;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_REV = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_OFFSET   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTH_LASERS    = 3'd4;

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_RIGHT = 2'd1;
	localparam logic [1:0] REQ_LEFT  = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	localparam logic [7:0] COLOR_FULL = 8'd255;
	localparam logic [7:0] COLOR_GRAY = 8'd175;
	localparam logic [7:0] COLOR_NONE = 8'd0;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [12:0] frame;
		logic [15:0] y_q4;
		logic [19:0] point_id;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
	} pt_t;

	typedef struct packed {
		logic [19:0] point_id_out;
		logic        from_left;
		logic [13:0] pseudo_frame;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic        culled;
	} res_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic mul;
		logic div_start;
		logic mem_read;
		logic check;
		logic clear;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       both;
		logic       div_busy;
		logic       keep;
	} dp_stat_t;

endpackage

// ----- design/spom_point_if.sv -----
// ----------------------------------------------------------------------------
// spom_point_if
// Valid/ready channel that carries one scan point or clear item.
// ----------------------------------------------------------------------------
interface spom_point_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [12:0] frame;
	logic [15:0] y_q4;
	logic [19:0] point_id;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;

	modport source (output valid, req_type, frame, y_q4, point_id, red_in, green_in, blue_in,
		input ready);
	modport sink (input valid, req_type, frame, y_q4, point_id, red_in, green_in, blue_in,
		output ready);
endinterface

// ----- design/spom_result_if.sv -----
// ----------------------------------------------------------------------------
// spom_result_if
// Valid/ready channel that carries one merged point.
// ----------------------------------------------------------------------------
interface spom_result_if;
	logic        valid;
	logic        ready;
	logic [19:0] point_id_out;
	logic        from_left;
	logic [13:0] pseudo_frame;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic        culled;

	modport source (output valid, point_id_out, from_left, pseudo_frame, red_out, green_out,
		blue_out, culled, input ready);
	modport sink (input valid, point_id_out, from_left, pseudo_frame, red_out, green_out,
		blue_out, culled, output ready);
endinterface

// ----- design/spom_div.sv -----
// ----------------------------------------------------------------------------
// spom_div
// Iterative restoring divider that yields a cell index, one quotient bit per
// cycle, saturated to the last cell.
// ----------------------------------------------------------------------------
module spom_div #(
	parameter int CELLS = spom_pkg::FRAME_CELLS_DEF,
	parameter int NW    = 24,
	parameter int DW    = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NW-1:0]              num,
	input  logic [DW-1:0]              den,
	output logic                       busy,
	output logic [$clog2(CELLS)-1:0]   cell_idx
);

	localparam int QB = $clog2(CELLS);
	localparam int CW = $clog2(QB + 1);
	localparam int XW = NW + DW + QB;
	localparam logic [QB-1:0] LAST = QB'(CELLS - 1);

	logic [NW-1:0]    rem_q;
	logic [DW+QB-1:0] dsh_q;
	logic [QB-1:0]    quo_q;
	logic             sat_q;
	logic [CW-1:0]    step_q;
	logic             busy_q;
	logic             ge;

	assign ge = XW'(rem_q) >= XW'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= CW'(QB);
		end else if (busy_q) begin
			step_q <= step_q - CW'(1);
			if (step_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= (DW+QB)'(den) << (QB - 1);
			quo_q <= '0;
			sat_q <= (den == '0) || (XW'(num) >= (XW'(den) << QB));
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - NW'(dsh_q);
			end
			quo_q <= (quo_q << 1) | QB'(ge);
			dsh_q <= dsh_q >> 1;
		end
	end

	assign busy     = busy_q;
	assign cell_idx = (sat_q || quo_q > LAST) ? LAST : quo_q;

endmodule

// ----- design/spom_dp.sv -----
// ----------------------------------------------------------------------------
// spom_dp
// Datapath: configuration registers, item registers, cell index arithmetic,
// the occupancy grid memory and the result register.
// ----------------------------------------------------------------------------
module spom_dp #(
	parameter int FRAME_CELLS  = spom_pkg::FRAME_CELLS_DEF,
	parameter int HEIGHT_CELLS = spom_pkg::HEIGHT_CELLS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [spom_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [spom_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  spom_pkg::pt_t                       pt,
	input  spom_pkg::ctl_cmd_t                  cmd,
	input  logic [$clog2(FRAME_CELLS)-1:0]      clr_addr,
	output spom_pkg::dp_stat_t                  stat,
	output spom_pkg::res_t                      res
);

	localparam int FB  = $clog2(FRAME_CELLS);
	localparam int HB  = $clog2(HEIGHT_CELLS);
	localparam int CNW = 14 + FB;
	localparam int RNW = 16 + HB;

	logic [12:0] fpr_q;
	logic [12:0] off_q;
	logic [11:0] max_y_q;
	logic        color_q;
	logic        both_q;

	spom_pkg::pt_t  item_q;
	spom_pkg::res_t res_q;
	logic [13:0]    pf_q;
	logic [CNW-1:0] num_col_q;
	logic [RNW-1:0] num_row_q;
	logic [HEIGHT_CELLS-1:0] rd_q;
	logic [HEIGHT_CELLS-1:0] grid_mem [FRAME_CELLS];

	logic [13:0]             sum;
	logic [13:0]             wrapped;
	logic [FB-1:0]           col;
	logic [HB-1:0]           row;
	logic                    col_busy;
	logic                    row_busy;
	logic                    occupied;
	logic                    mem_we;
	logic [FB-1:0]           mem_wa;
	logic [HEIGHT_CELLS-1:0] mem_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpr_q   <= 13'd1;
			off_q   <= 13'd0;
			max_y_q <= 12'd1;
			color_q <= 1'b0;
			both_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				spom_pkg::CFG_FRAMES_PER_REV: fpr_q   <= cfg_data;
				spom_pkg::CFG_FRAME_OFFSET:   off_q   <= cfg_data;
				spom_pkg::CFG_MAX_Y:          max_y_q <= cfg_data[11:0];
				spom_pkg::CFG_COLOR_MODE:     color_q <= cfg_data[0];
				spom_pkg::CFG_BOTH_LASERS:    both_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign sum     = {1'b0, item_q.frame} + {1'b0, off_q};
	assign wrapped = (sum >= {1'b0, fpr_q}) ? sum - {1'b0, fpr_q} : sum;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= pt;
		end
		if (cmd.decode) begin
			pf_q <= (item_q.req_type == spom_pkg::REQ_LEFT && both_q) ? wrapped
				: {1'b0, item_q.frame};
		end
		if (cmd.mul) begin
			num_col_q <= CNW'(pf_q) * CNW'(FRAME_CELLS - 1);
			num_row_q <= RNW'(item_q.y_q4) * RNW'(HEIGHT_CELLS - 1);
		end
	end

	spom_div #(.CELLS(FRAME_CELLS), .NW(CNW), .DW(13)) u_col_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.num      (num_col_q),
		.den      (fpr_q),
		.busy     (col_busy),
		.cell_idx (col)
	);

	spom_div #(.CELLS(HEIGHT_CELLS), .NW(RNW), .DW(16)) u_row_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.num      (num_row_q),
		.den      ({max_y_q, 4'd0}),
		.busy     (row_busy),
		.cell_idx (row)
	);

	assign occupied = rd_q[row];
	assign mem_we   = cmd.clear || (cmd.check && item_q.req_type == spom_pkg::REQ_RIGHT);
	assign mem_wa   = cmd.clear ? clr_addr : col;
	assign mem_wd   = cmd.clear ? '0 : (rd_q | (HEIGHT_CELLS'(1) << row));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_wa] <= mem_wd;
		end
		if (cmd.mem_read) begin
			rd_q <= grid_mem[col];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.point_id_out <= item_q.point_id;
			res_q.from_left    <= item_q.req_type == spom_pkg::REQ_LEFT;
			res_q.pseudo_frame <= pf_q;
			res_q.red_out      <= item_q.red_in;
			res_q.green_out    <= item_q.green_in;
			res_q.blue_out     <= item_q.blue_in;
			res_q.culled       <= 1'b0;
			if (both_q && color_q) begin
				if (item_q.req_type == spom_pkg::REQ_RIGHT) begin
					res_q.red_out   <= spom_pkg::COLOR_NONE;
					res_q.green_out <= spom_pkg::COLOR_NONE;
					res_q.blue_out  <= spom_pkg::COLOR_NONE;
				end else if (occupied) begin
					res_q.red_out   <= spom_pkg::COLOR_GRAY;
					res_q.green_out <= spom_pkg::COLOR_GRAY;
					res_q.blue_out  <= spom_pkg::COLOR_GRAY;
					res_q.culled    <= 1'b1;
				end else begin
					res_q.red_out   <= spom_pkg::COLOR_FULL;
					res_q.green_out <= spom_pkg::COLOR_NONE;
					res_q.blue_out  <= spom_pkg::COLOR_NONE;
				end
			end
		end
	end

	assign stat.req      = item_q.req_type;
	assign stat.both     = both_q;
	assign stat.div_busy = col_busy || row_busy;
	assign stat.keep     = (item_q.req_type == spom_pkg::REQ_RIGHT) || !occupied || color_q;
	assign res           = res_q;

endmodule

// ----- design/spom_ctl.sv -----
// ----------------------------------------------------------------------------
// spom_ctl
// Controller: sequences each two-laser point through decode, scaling, division,
// grid access and result hand-off, and sweeps the grid on reset and on clear.
// ----------------------------------------------------------------------------
module spom_ctl #(
	parameter int FRAME_CELLS = spom_pkg::FRAME_CELLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	output logic                            out_valid,
	input  logic                            out_ready,
	input  spom_pkg::dp_stat_t              stat,
	output spom_pkg::ctl_cmd_t              cmd,
	output logic [$clog2(FRAME_CELLS)-1:0]  clr_addr
);

	localparam int FB = $clog2(FRAME_CELLS);
	localparam logic [FB-1:0] CLR_LAST = FB'(FRAME_CELLS - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_START  = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;
	localparam logic [2:0] ST_CHECK  = 3'd6;
	localparam logic [2:0] ST_CLEAR  = 3'd7;

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [FB-1:0] clr_q;
	logic          emit_pend_q;
	logic          out_vld_q;
	logic          slot_free;

	assign slot_free = !out_vld_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && !emit_pend_q && in_valid;
		cmd.decode    = state_q == ST_DECODE;
		cmd.mul       = state_q == ST_MUL;
		cmd.div_start = state_q == ST_START;
		cmd.mem_read  = (state_q == ST_DIV) && !stat.div_busy;
		cmd.check     = state_q == ST_CHECK;
		cmd.clear     = state_q == ST_CLEAR;
		cmd.emit      = (state_q == ST_IDLE) && emit_pend_q && slot_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.req)
					spom_pkg::REQ_CLEAR: state_d = ST_CLEAR;
					spom_pkg::REQ_NONE:  state_d = ST_IDLE;
					default:             state_d = stat.both ? ST_MUL : ST_IDLE;
				endcase
			end
			ST_MUL:   state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV: begin
				if (!stat.div_busy) begin
					state_d = ST_READ;
				end
			end
			ST_READ:  state_d = ST_CHECK;
			ST_CHECK: state_d = ST_IDLE;
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			emit_pend_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= (clr_q == CLR_LAST) ? '0 : clr_q + FB'(1);
			end
			if (state_q == ST_DECODE && !stat.both &&
				(stat.req == spom_pkg::REQ_RIGHT || stat.req == spom_pkg::REQ_LEFT)) begin
				emit_pend_q <= 1'b1;
			end else if (state_q == ST_CHECK && stat.keep) begin
				emit_pend_q <= 1'b1;
			end else if (cmd.emit) begin
				emit_pend_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE) && !emit_pend_q;
	assign out_valid = out_vld_q;
	assign clr_addr  = clr_q;

`ifndef SYNTHESIS
	a_load_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_DECODE)
		else $error("accepted item did not move to decode");
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> stat.div_busy)
		else $error("dividers not busy after start");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_vld_q && !emit_pend_q)
		else $error("emitted item not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ready) |=> $stable(out_vld_q) && !$past(cmd.emit))
		else $error("held result overwritten");
`endif

endmodule

// ----- design/scan_point_occupancy_merge.sv -----
// ----------------------------------------------------------------------------
// scan_point_occupancy_merge
// Merges right and left laser scan points through a one-bit occupancy grid.
// A point's result waits on the two iterative cell-index dividers, and the
// next item is taken only once the result has left for the output register;
// one item is in work at a time, and a finished result waits in the output
// register. A single-laser point goes from decode straight to the output.
// A clear item sweeps the grid one row per cycle. After reset the grid is
// swept the same way before the first item is taken; configuration writes
// are taken at any time.
// ----------------------------------------------------------------------------
module scan_point_occupancy_merge #(
	parameter int FRAME_CELLS  = spom_pkg::FRAME_CELLS_DEF,
	parameter int HEIGHT_CELLS = spom_pkg::HEIGHT_CELLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [spom_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [spom_pkg::CFG_DATA_W-1:0] cfg_data,
	spom_point_if.sink                      points,
	spom_result_if.source                   results
);

	spom_pkg::pt_t                  pt;
	spom_pkg::res_t                 res;
	spom_pkg::ctl_cmd_t             cmd;
	spom_pkg::dp_stat_t             stat;
	logic [$clog2(FRAME_CELLS)-1:0] clr_addr;

	assign pt.req_type = points.req_type;
	assign pt.frame    = points.frame;
	assign pt.y_q4     = points.y_q4;
	assign pt.point_id = points.point_id;
	assign pt.red_in   = points.red_in;
	assign pt.green_in = points.green_in;
	assign pt.blue_in  = points.blue_in;

	spom_ctl #(.FRAME_CELLS(FRAME_CELLS)) u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (points.valid),
		.in_ready  (points.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd),
		.clr_addr  (clr_addr)
	);

	spom_dp #(.FRAME_CELLS(FRAME_CELLS), .HEIGHT_CELLS(HEIGHT_CELLS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pt       (pt),
		.cmd      (cmd),
		.clr_addr (clr_addr),
		.stat     (stat),
		.res      (res)
	);

	assign results.point_id_out = res.point_id_out;
	assign results.from_left    = res.from_left;
	assign results.pseudo_frame = res.pseudo_frame;
	assign results.red_out      = res.red_out;
	assign results.green_out    = res.green_out;
	assign results.blue_out     = res.blue_out;
	assign results.culled       = res.culled;

endmodule

// ----- tb/sv/spom_merge_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spom_merge_checker
// Follows the register writes and both channels of the scan point occupancy
// merge, predicts each merged point from its own copy of the occupancy grid
// and settings, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module spom_merge_checker #(
	parameter int FRAME_CELLS  = spom_pkg::FRAME_CELLS_DEF,
	parameter int HEIGHT_CELLS = spom_pkg::HEIGHT_CELLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [spom_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [spom_pkg::CFG_DATA_W-1:0] cfg_data,
	spom_point_if                           points,
	spom_result_if                          results,
	output int                              errors,
	output int                              outstanding
);

	logic [12:0] frames_per_rev;
	logic [12:0] frame_offset;
	logic [11:0] max_y;
	logic        color_mode;
	logic        both_lasers;

	bit             marked_cells[int unsigned];
	spom_pkg::res_t merged_due[$];

	task automatic report_mismatch(input string msg);
		if (errors < 40) begin
			$display("%0t mismatch: %s", $realtime, msg);
		end
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
		end
	endtask

	function automatic int unsigned scale_to_cell(input longint unsigned num,
			input longint unsigned den, input int cells);
		longint unsigned last;
		longint unsigned q;
		last = cells - 1;
		if (den == 0) begin
			return int'(last);
		end
		q = num * last / den;
		return int'((q > last) ? last : q);
	endfunction

	function automatic int unsigned cell_of(input longint unsigned pf,
			input longint unsigned yq4);
		return scale_to_cell(pf, 64'(frames_per_rev), FRAME_CELLS) * HEIGHT_CELLS
			+ scale_to_cell(yq4, 64'(max_y) * 16, HEIGHT_CELLS);
	endfunction

	// Returns 1 when the point yields a merged point, and updates the grid.
	function automatic bit merge_point(input spom_pkg::pt_t p, output spom_pkg::res_t r);
		logic [13:0] pf;
		bit          hit;
		r = '0;
		r.point_id_out = p.point_id;
		r.from_left = (p.req_type == spom_pkg::REQ_LEFT);
		r.red_out = p.red_in;
		r.green_out = p.green_in;
		r.blue_out = p.blue_in;
		case (p.req_type)
			spom_pkg::REQ_CLEAR: begin
				marked_cells.delete();
				return 1'b0;
			end
			spom_pkg::REQ_NONE: begin
				return 1'b0;
			end
			default: ;
		endcase
		if (!both_lasers) begin
			r.pseudo_frame = 14'(p.frame);
			return 1'b1;
		end
		if (p.req_type == spom_pkg::REQ_RIGHT) begin
			marked_cells[cell_of(p.frame, p.y_q4)] = 1'b1;
			r.pseudo_frame = 14'(p.frame);
			if (color_mode) begin
				r.red_out = spom_pkg::COLOR_NONE;
				r.green_out = spom_pkg::COLOR_NONE;
				r.blue_out = spom_pkg::COLOR_NONE;
			end
			return 1'b1;
		end
		pf = 14'(p.frame) + 14'(frame_offset);
		if (pf >= 14'(frames_per_rev)) begin
			pf = pf - 14'(frames_per_rev);
		end
		r.pseudo_frame = pf;
		hit = marked_cells.exists(cell_of(pf, p.y_q4));
		if (!hit) begin
			if (color_mode) begin
				r.red_out = spom_pkg::COLOR_FULL;
				r.green_out = spom_pkg::COLOR_NONE;
				r.blue_out = spom_pkg::COLOR_NONE;
			end
			return 1'b1;
		end
		if (color_mode) begin
			r.red_out = spom_pkg::COLOR_GRAY;
			r.green_out = spom_pkg::COLOR_GRAY;
			r.blue_out = spom_pkg::COLOR_GRAY;
			r.culled = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		spom_pkg::res_t due;
		spom_pkg::res_t fresh;
		spom_pkg::pt_t  taken;
		if (!arst_n) begin
			frames_per_rev = 13'd1;
			frame_offset = 13'd0;
			max_y = 12'd1;
			color_mode = 1'b0;
			both_lasers = 1'b1;
			marked_cells.delete();
			merged_due.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					spom_pkg::CFG_FRAMES_PER_REV: frames_per_rev = cfg_data[12:0];
					spom_pkg::CFG_FRAME_OFFSET:   frame_offset = cfg_data[12:0];
					spom_pkg::CFG_MAX_Y:          max_y = cfg_data[11:0];
					spom_pkg::CFG_COLOR_MODE:     color_mode = cfg_data[0];
					spom_pkg::CFG_BOTH_LASERS:    both_lasers = cfg_data[0];
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				if (merged_due.size() == 0) begin
					report_mismatch($sformatf("point %0h merged with nothing expected",
						results.point_id_out));
				end else begin
					due = merged_due.pop_front();
					check_field("point_id_out", results.point_id_out, due.point_id_out);
					check_field("from_left", results.from_left, due.from_left);
					check_field("pseudo_frame", results.pseudo_frame, due.pseudo_frame);
					check_field("red_out", results.red_out, due.red_out);
					check_field("green_out", results.green_out, due.green_out);
					check_field("blue_out", results.blue_out, due.blue_out);
					check_field("culled", results.culled, due.culled);
				end
			end
			if (points.valid && points.ready) begin
				taken = {points.req_type, points.frame, points.y_q4, points.point_id,
					points.red_in, points.green_in, points.blue_in};
				if (merge_point(taken, fresh)) begin
					merged_due = {merged_due, fresh};
				end
			end
			outstanding = merged_due.size();
		end
	end

endmodule

// ----- tb/sv/tb_scan_point_occupancy_merge.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scan_point_occupancy_merge
// Drives scan revolutions of right and left laser points, clear items and
// stray codes through the merge under several register settings, with
// random stalls on both channels; the checker beside the block predicts
// and compares every merged point.
// ----------------------------------------------------------------------------
module tb_scan_point_occupancy_merge;

	localparam int SETTLE_CYCLES = spom_pkg::FRAME_CELLS_DEF + 64;
	localparam int QUIET_LIMIT   = 20000;
	localparam int PHASE_POINTS  = 135;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [spom_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [spom_pkg::CFG_DATA_W-1:0] cfg_data;

	spom_point_if  points();
	spom_result_if results();

	int errors;
	int outstanding;
	int idle_pct;
	bit calm;
	int stall_left;
	int quiet_cycles;
	int points_sent;
	int fpr_now;
	int off_now;
	int maxy_now;

	logic [12:0] ring_frame[$];
	logic [15:0] ring_y[$];

	scan_point_occupancy_merge u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.points   (points),
		.results  (results)
	);

	spom_merge_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.points      (points),
		.results     (results),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		results.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				results.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				results.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 14);
				results.ready <= 1'b0;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (points.valid && points.ready) ||
				(results.valid && results.ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[scan_point_occupancy_merge] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic spom_pkg::pt_t make_point(input logic [1:0] req,
			input logic [12:0] frame, input logic [15:0] y);
		spom_pkg::pt_t p;
		p.req_type = req;
		p.frame = frame;
		p.y_q4 = y;
		p.point_id = 20'($urandom);
		p.red_in = 8'($urandom);
		p.green_in = 8'($urandom);
		p.blue_in = 8'($urandom);
		return p;
	endfunction

	function automatic logic [15:0] pick_height();
		int span;
		span = maxy_now * 16 + 15;
		if (span > 65535) begin
			span = 65535;
		end
		if ($urandom_range(0, 7) == 0) begin
			return 16'($urandom);
		end
		return 16'($urandom_range(0, span));
	endfunction

	function automatic logic [12:0] pick_frame();
		if (fpr_now == 0 || $urandom_range(0, 9) == 0) begin
			return 13'($urandom);
		end
		return 13'($urandom_range(0, fpr_now - 1));
	endfunction

	// Starts and ends at a falling edge; valid stays high on return.
	task automatic send_point(input spom_pkg::pt_t p);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			points.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		points.valid <= 1'b1;
		points.req_type <= p.req_type;
		points.frame <= p.frame;
		points.y_q4 <= p.y_q4;
		points.point_id <= p.point_id;
		points.red_in <= p.red_in;
		points.green_in <= p.green_in;
		points.blue_in <= p.blue_in;
		@(posedge clk);
		while (!points.ready) @(posedge clk);
		if (p.req_type != spom_pkg::REQ_NONE) begin
			points_sent++;
		end
		@(negedge clk);
	endtask

	task automatic drain();
		points.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	// A dropped point or a clear item leaves nothing to wait for, so the
	// block gets a full clear time on top of the drain.
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [spom_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= spom_pkg::CFG_DATA_W'(value);
		@(negedge clk);
	endtask

	task automatic configure(input int fpr, input int off, input int maxy,
			input int color, input int both);
		settle();
		write_reg(spom_pkg::CFG_FRAMES_PER_REV, fpr);
		write_reg(spom_pkg::CFG_FRAME_OFFSET, off);
		write_reg(spom_pkg::CFG_MAX_Y, maxy);
		write_reg(spom_pkg::CFG_COLOR_MODE, color);
		write_reg(spom_pkg::CFG_BOTH_LASERS, both);
		cfg_we <= 1'b0;
		@(negedge clk);
		fpr_now = fpr;
		off_now = off;
		maxy_now = maxy;
	endtask

	// One revolution: an optional clear, right points, then left points of
	// which most land on the cell of an earlier right point.
	task automatic run_revolution();
		int            nr;
		int            nl;
		int            k;
		int            pick;
		int            lf;
		spom_pkg::pt_t p;
		if ($urandom_range(0, 3) != 0) begin
			send_point(make_point(spom_pkg::REQ_CLEAR, 13'($urandom), 16'($urandom)));
			ring_frame.delete();
			ring_y.delete();
		end
		nr = $urandom_range(3, 24);
		nl = $urandom_range(3, 24);
		for (k = 0; k < nr; k++) begin
			p = make_point(spom_pkg::REQ_RIGHT, pick_frame(), pick_height());
			ring_frame = {ring_frame, p.frame};
			ring_y = {ring_y, p.y_q4};
			send_point(p);
			if ($urandom_range(0, 24) == 0) begin
				send_point(make_point(spom_pkg::REQ_NONE, 13'($urandom), 16'($urandom)));
			end
		end
		for (k = 0; k < nl; k++) begin
			p = make_point(spom_pkg::REQ_LEFT, pick_frame(), pick_height());
			if (ring_frame.size() != 0 && $urandom_range(0, 9) < 6) begin
				pick = $urandom_range(0, ring_frame.size() - 1);
				lf = int'(ring_frame[pick]) - off_now;
				if (lf < 0) begin
					lf += fpr_now;
				end
				if (lf >= 0 && lf <= 8191) begin
					p.frame = 13'(lf);
				end
				p.y_q4 = ring_y[pick];
			end
			send_point(p);
		end
	endtask

	initial begin
		spom_pkg::pt_t p;
		int            phase;
		int            goal;
		int            fpr;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= spom_pkg::CFG_FRAMES_PER_REV;
		cfg_data <= '0;
		points.valid <= 1'b0;
		points.req_type <= spom_pkg::REQ_CLEAR;
		points.frame <= '0;
		points.y_q4 <= '0;
		points.point_id <= '0;
		points.red_in <= '0;
		points.green_in <= '0;
		points.blue_in <= '0;
		calm = 1'b0;
		idle_pct = 20;
		points_sent = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Color mode: culled hits, wrap of the pseudo frame, saturated cells.
		configure(8, 3, 4, 1, 1);
		send_point(make_point(spom_pkg::REQ_CLEAR, 13'd0, 16'd0));
		p = make_point(spom_pkg::REQ_RIGHT, 13'd0, 16'd0);
		p.point_id = '0;
		p.red_in = '0;
		p.green_in = '0;
		p.blue_in = '0;
		send_point(p);
		p = make_point(spom_pkg::REQ_RIGHT, 13'd5, 16'd64);
		p.point_id = '1;
		p.red_in = '1;
		p.green_in = '1;
		p.blue_in = '1;
		send_point(p);
		send_point(make_point(spom_pkg::REQ_LEFT, 13'd2, 16'd64));
		send_point(make_point(spom_pkg::REQ_LEFT, 13'd5, 16'd0));
		send_point(make_point(spom_pkg::REQ_LEFT, 13'd8191, 16'd65535));
		send_point(make_point(spom_pkg::REQ_NONE, 13'd8191, 16'd65535));
		send_point(make_point(spom_pkg::REQ_RIGHT, 13'd8191, 16'd65535));
		send_point(make_point(spom_pkg::REQ_LEFT, 13'd8191, 16'd65535));
		send_point(make_point(spom_pkg::REQ_LEFT, 13'd1, 16'd0));

		// Right laser preferred: the occupied left point is dropped.
		configure(8, 3, 4, 0, 1);
		send_point(make_point(spom_pkg::REQ_LEFT, 13'd8191, 16'd65535));
		send_point(make_point(spom_pkg::REQ_LEFT, 13'd1, 16'd0));
		send_point(make_point(spom_pkg::REQ_RIGHT, 13'd3, 16'd32));

		// Single laser: points pass unchanged; clear still wipes the grid.
		configure(8, 3, 4, 0, 0);
		send_point(make_point(spom_pkg::REQ_RIGHT, 13'd7, 16'd16));
		send_point(make_point(spom_pkg::REQ_LEFT, 13'd6, 16'd16));
		send_point(make_point(spom_pkg::REQ_CLEAR, 13'd0, 16'd0));

		// Zero divisors put every point in the last cell; no wrap applies.
		configure(0, 5, 0, 1, 1);
		send_point(make_point(spom_pkg::REQ_RIGHT, 13'd100, 16'd500));
		send_point(make_point(spom_pkg::REQ_LEFT, 13'd8191, 16'd0));
		send_point(make_point(spom_pkg::REQ_LEFT, 13'd0, 16'd65535));

		for (phase = 0; phase < 8; phase++) begin
			fpr = $urandom_range(2, 64);
			case (phase)
				0: configure(8191, 8191, 4095, 0, 1);
				1: configure(1, 0, 1, 1, 1);
				2: configure(fpr, $urandom_range(0, fpr - 1), $urandom_range(1, 16), 1, 1);
				3: configure(fpr, $urandom_range(0, fpr - 1), $urandom_range(1, 16), 0, 1);
				4: configure($urandom_range(1, 8191), $urandom_range(0, 8191),
					$urandom_range(1, 4095), $urandom_range(0, 1), 1);
				5: configure($urandom_range(1, 8191), $urandom_range(0, 8191),
					$urandom_range(1, 4095), $urandom_range(0, 1), 0);
				6: configure($urandom_range(100, 2000), $urandom_range(0, 8191),
					$urandom_range(1, 200), 1, 1);
				default: configure(360, 90, 100, $urandom_range(0, 1), 1);
			endcase
			calm = (phase == 7);
			idle_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 30);
			ring_frame.delete();
			ring_y.delete();
			goal = points_sent + PHASE_POINTS;
			while (points_sent < goal) begin
				run_revolution();
				if ($urandom_range(0, 9) == 0) begin
					drain();
				end
			end
		end

		settle();
		if (errors == 0) begin
			$display("[scan_point_occupancy_merge] OK");
		end else begin
			$display("[scan_point_occupancy_merge] ERROR");
		end
		$finish;
	end

endmodule
